### rtl/tpose_pkg.sv
// ----------------------------------------------------------------------------
// tpose_pkg
// Shared types and constants for the two-plane overlay sprite row encoder.
// ----------------------------------------------------------------------------
package tpose_pkg;

  localparam int PIXELS_PER_ROW = 8;
  localparam int COLOR_W        = 8;
  localparam int ROW_W          = 8;

  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [PIXELS_PER_ROW-1:0] mask_t;
  typedef logic [ROW_W-1:0]          row_count_t;

  localparam color_t LOW_BIT_CLEAR = color_t'(8'hFE);
  localparam color_t LOW_BIT       = color_t'(8'h01);

  // classified row, handed from the front to the back
  typedef struct packed {
    mask_t  plane0;
    mask_t  plane1;
    mask_t  err;
    color_t c0;
    color_t c1;
    logic   have0;
    logic   have1;
    logic   last_row;
  } row_class_t;

endpackage

### rtl/tpose_if.sv
// ----------------------------------------------------------------------------
// tpose_if
// Valid/ready channels for pixel rows and for encoded sprite rows.
// ----------------------------------------------------------------------------
interface tpose_row_if;
  logic                  valid;
  logic                  ready;
  tpose_pkg::color_t     pixel_0;
  tpose_pkg::color_t     pixel_1;
  tpose_pkg::color_t     pixel_2;
  tpose_pkg::color_t     pixel_3;
  tpose_pkg::color_t     pixel_4;
  tpose_pkg::color_t     pixel_5;
  tpose_pkg::color_t     pixel_6;
  tpose_pkg::color_t     pixel_7;
  logic                  last_row;

  modport source (
    output valid, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7, last_row,
    input  ready
  );
  modport sink (
    input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7, last_row,
    output ready
  );
endinterface

interface tpose_sprite_if;
  logic                   valid;
  logic                   ready;
  tpose_pkg::mask_t       plane_zero;
  tpose_pkg::mask_t       plane_one;
  tpose_pkg::color_t      color_zero;
  tpose_pkg::color_t      color_one;
  tpose_pkg::row_count_t  row_index;
  tpose_pkg::mask_t       error_mask;

  modport source (
    output valid, plane_zero, plane_one, color_zero, color_one,
           row_index, error_mask,
    input  ready
  );
  modport sink (
    input  valid, plane_zero, plane_one, color_zero, color_one,
           row_index, error_mask,
    output ready
  );
endinterface

### rtl/tpose_front.sv
// ----------------------------------------------------------------------------
// tpose_front
// Accepts pixel rows, picks the two row colours and classifies each pixel.
// ----------------------------------------------------------------------------
module tpose_front (
  tpose_row_if.sink              row,
  input  tpose_pkg::color_t      background,
  output logic                   push,
  output tpose_pkg::row_class_t  push_data,
  input  logic                   push_ready
);

  tpose_pkg::color_t raw [tpose_pkg::PIXELS_PER_ROW];
  tpose_pkg::color_t pix [tpose_pkg::PIXELS_PER_ROW];
  tpose_pkg::mask_t  opaque;
  tpose_pkg::color_t c0;
  tpose_pkg::color_t c1;
  tpose_pkg::color_t c01;
  logic              have0;
  logic              have1;
  tpose_pkg::mask_t  plane0;
  tpose_pkg::mask_t  plane1;
  tpose_pkg::mask_t  err;

  assign raw[0] = row.pixel_0;
  assign raw[1] = row.pixel_1;
  assign raw[2] = row.pixel_2;
  assign raw[3] = row.pixel_3;
  assign raw[4] = row.pixel_4;
  assign raw[5] = row.pixel_5;
  assign raw[6] = row.pixel_6;
  assign raw[7] = row.pixel_7;

  always_comb begin
    for (int i = 0; i < tpose_pkg::PIXELS_PER_ROW; i++) begin
      pix[i]    = raw[i] & tpose_pkg::LOW_BIT_CLEAR;
      opaque[i] = (raw[i] != background);
    end
  end

  // left to right colour pick
  always_comb begin
    have0 = 1'b0;
    have1 = 1'b0;
    c0    = '0;
    c1    = '0;
    for (int i = 0; i < tpose_pkg::PIXELS_PER_ROW; i++) begin
      if (opaque[i]) begin
        if (!have0) begin
          c0    = pix[i];
          have0 = 1'b1;
        end else if ((pix[i] != c0) && !have1) begin
          c1    = pix[i];
          have1 = 1'b1;
        end
      end
    end
  end

  assign c01 = c0 | c1;

  always_comb begin
    plane0 = '0;
    plane1 = '0;
    err    = '0;
    for (int i = 0; i < tpose_pkg::PIXELS_PER_ROW; i++) begin
      if (opaque[i]) begin
        if (pix[i] == c0) begin
          plane0[tpose_pkg::PIXELS_PER_ROW-1-i] = 1'b1;
        end else if (have1 && (pix[i] == c1)) begin
          plane1[tpose_pkg::PIXELS_PER_ROW-1-i] = 1'b1;
        end else if (have1 && (pix[i] == c01)) begin
          plane0[tpose_pkg::PIXELS_PER_ROW-1-i] = 1'b1;
          plane1[tpose_pkg::PIXELS_PER_ROW-1-i] = 1'b1;
        end else begin
          err[tpose_pkg::PIXELS_PER_ROW-1-i] = 1'b1;
        end
      end
    end
  end

  assign push      = row.valid;
  assign row.ready = push_ready;

  always_comb begin
    push_data.plane0   = plane0;
    push_data.plane1   = plane1;
    push_data.err      = err;
    push_data.c0       = c0;
    push_data.c1       = c1;
    push_data.have0    = have0;
    push_data.have1    = have1;
    push_data.last_row = row.last_row;
  end

endmodule

### rtl/tpose_queue.sv
// ----------------------------------------------------------------------------
// tpose_queue
// Short register queue of classified rows between front and back.
// ----------------------------------------------------------------------------
module tpose_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tpose_pkg::row_class_t  push_data,
  output logic                   push_ready,
  output logic                   pop_valid,
  output tpose_pkg::row_class_t  pop_data,
  input  logic                   pop
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  tpose_pkg::row_class_t entries [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [COUNT_W-1:0]    count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != COUNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/tpose_back.sv
// ----------------------------------------------------------------------------
// tpose_back
// Resolves missing colours from the previous row, numbers rows and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
module tpose_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  input  tpose_pkg::row_class_t  pop_data,
  output logic                   pop,
  tpose_sprite_if.source         result
);

  tpose_pkg::color_t     prior_c0;
  tpose_pkg::color_t     prior_c1;
  tpose_pkg::row_count_t row_counter;
  tpose_pkg::color_t     c0_next;
  tpose_pkg::color_t     c1_next;
  logic                  out_valid;

  assign pop          = pop_valid && (!out_valid || result.ready);
  assign result.valid = out_valid;

  always_comb begin
    c0_next = pop_data.have0 ? pop_data.c0 : (prior_c0 & tpose_pkg::LOW_BIT_CLEAR);
    c1_next = pop_data.have1 ? pop_data.c1 : (prior_c1 & tpose_pkg::LOW_BIT_CLEAR);
    if (pop_data.last_row) begin
      c1_next = c1_next | tpose_pkg::LOW_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      prior_c0    <= '0;
      prior_c1    <= '0;
      row_counter <= '0;
    end else begin
      if (pop) begin
        out_valid   <= 1'b1;
        prior_c0    <= c0_next;
        prior_c1    <= c1_next;
        row_counter <= row_counter + 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.plane_zero <= pop_data.plane0;
      result.plane_one  <= pop_data.plane1;
      result.color_zero <= c0_next;
      result.color_one  <= c1_next;
      result.row_index  <= row_counter;
      result.error_mask <= pop_data.err;
    end
  end

endmodule

### rtl/two_plane_overlay_sprite_encoder_unit.sv
// ----------------------------------------------------------------------------
// two_plane_overlay_sprite_encoder_unit
// Encodes rows of eight palette pixels as two overlaid one-bit sprite planes.
// datapath: an accepted row is registered in the queue, then in the output register
// throughput: one row per cycle while result.ready is high; classify and resolve are combinational
// a full queue and output register absorb QUEUE_DEPTH + 1 rows of stall
// reset: synchronous; clears queue, output valid, prior colours, row counter
// ----------------------------------------------------------------------------
module two_plane_overlay_sprite_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               background_we,
  input  tpose_pkg::color_t  background_data,
  tpose_row_if.sink          row,
  tpose_sprite_if.source     result
);

  tpose_pkg::color_t     background;
  logic                  push;
  logic                  push_ready;
  tpose_pkg::row_class_t push_data;
  logic                  pop_valid;
  logic                  pop;
  tpose_pkg::row_class_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      background <= '0;
    end else if (background_we) begin
      background <= background_data;
    end
  end

  tpose_front u_front (
    .row        (row),
    .background (background),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  tpose_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  tpose_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .result    (result)
  );

endmodule

### rtl/tpose_checker.sv
// ----------------------------------------------------------------------------
// tpose_checker
// Port-level checks on the result channel of the sprite row encoder.
// ----------------------------------------------------------------------------
module tpose_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  tpose_pkg::mask_t       plane_zero,
  input  tpose_pkg::mask_t       plane_one,
  input  tpose_pkg::color_t      color_zero,
  input  tpose_pkg::row_count_t  row_index,
  input  tpose_pkg::mask_t       error_mask
);

  tpose_pkg::row_count_t expected_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_index <= '0;
    end else if (out_valid && out_ready) begin
      expected_index <= expected_index + 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> row_index == expected_index)
    else $error("row index out of sequence");

  a_color_zero_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !color_zero[0])
    else $error("color zero low bit set");

  a_error_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_mask & (plane_zero | plane_one)) == '0)
    else $error("error pixel also drawn");

endmodule

bind two_plane_overlay_sprite_encoder_unit tpose_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .plane_zero (result.plane_zero),
  .plane_one  (result.plane_one),
  .color_zero (result.color_zero),
  .row_index  (result.row_index),
  .error_mask (result.error_mask)
);
